>>> src/longest_remaining_time_scheduler_top_defines.svh
// Assertion macros used by the scheduler RTL
`ifndef LONGEST_REMAINING_TIME_SCHEDULER_TOP_DEFINES_SVH
`define LONGEST_REMAINING_TIME_SCHEDULER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define LRTS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause
`define LRTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/lrts_pkg.sv
// Shared widths, codes and slot entry type for the scheduler
package lrts_pkg;

   localparam int TIME_W = 16;
   localparam int PROC_W = 4;
   localparam int ACT_W  = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic              started;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
   } entry_type;

endpackage

>>> src/lrts_store.sv
// Process slot memory with per-entry valid bits; unwritten entries read as zero
module lrts_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  lrts_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output lrts_pkg::entry_type rd_data
);

   lrts_pkg::entry_type mem_ff [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   lrts_pkg::entry_type rd_word_ff;
   logic                rd_valid_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Mark written entries; reset empties the whole store at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Register the read word and its valid bit
   always_ff @(posedge clock) begin
      rd_word_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

>>> src/longest_remaining_time_scheduler_top.sv
// A tick scans limit slots (limit = min(active_count, MAX_PROCS)) and then registers its result.
// A tick issues one slot read per cycle, compares each slot in the cycle after its read, then enters a result state.
// A tick is taken only while not busy, so ticks do not overlap; a load is written in idle and gives no result.
// busy is high after a tick is accepted until its result is shown; rsp_valid pulses for one cycle.
// Reset (synchronous, active high) clears time, active_count and every slot to zero at once.
`include "longest_remaining_time_scheduler_top_defines.svh"

module longest_remaining_time_scheduler_top #(
   parameter int MAX_PROCS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [lrts_pkg::PROC_W-1:0]   req_slot_index,
   input  logic [lrts_pkg::TIME_W-1:0]   req_arrival_time,
   input  logic [lrts_pkg::TIME_W-1:0]   req_burst_length,
   input  logic                          csr_write_enable,
   input  logic [lrts_pkg::ACT_W-1:0]    csr_write_data,
   output logic                          rsp_valid,
   output logic [lrts_pkg::TIME_W-1:0]   rsp_slot_time,
   output logic                          rsp_idle,
   output logic [lrts_pkg::PROC_W-1:0]   rsp_chosen_process,
   output logic                          rsp_first_run,
   output logic [lrts_pkg::TIME_W-1:0]   rsp_response_time,
   output logic                          rsp_finished,
   output logic [lrts_pkg::TIME_W-1:0]   rsp_completion_time,
   output logic [lrts_pkg::TIME_W-1:0]   rsp_waiting_time,
   output logic [lrts_pkg::TIME_W-1:0]   rsp_turnaround_time
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = lrts_pkg::TIME_W;
   localparam int PW    = lrts_pkg::PROC_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_RESULT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [TW-1:0]          time_ff, time_in;
   logic [lrts_pkg::ACT_W-1:0] active_ff;
   logic [CNT_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   lrts_pkg::entry_type    best_ff, best_in;

   logic                   rsp_valid_ff;
   logic [TW-1:0]          rsp_slot_time_ff;
   logic                   rsp_idle_ff;
   logic [PW-1:0]          rsp_chosen_ff;
   logic                   rsp_first_ff;
   logic [TW-1:0]          rsp_response_ff;
   logic                   rsp_finished_ff;
   logic [TW-1:0]          rsp_completion_ff;
   logic [TW-1:0]          rsp_waiting_ff;
   logic [TW-1:0]          rsp_turnaround_ff;

   logic                   accept;
   logic [CNT_W-1:0]       limit;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   lrts_pkg::entry_type    wr_data;
   logic [IDX_W-1:0]       rd_addr;
   lrts_pkg::entry_type    rd_data;
   logic [IDX_W+PW-1:0]    slot_ext;
   logic [PW+IDX_W-1:0]    chosen_ext;
   logic                   slot_ok;
   logic                   cand_take;
   logic [TW-1:0]          done_time;
   logic [TW-1:0]          resp_time;
   logic [TW-1:0]          tat_time;
   logic [TW-1:0]          wait_time;
   logic                   fin;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Clamp the scan length to the slot count
   assign limit = (32'(active_ff) > MAX_PROCS) ? CNT_W'(MAX_PROCS) : CNT_W'(active_ff);

   assign slot_ext   = {{IDX_W{1'b0}}, req_slot_index};
   assign slot_ok    = (32'(req_slot_index) < MAX_PROCS);
   assign chosen_ext = {{PW{1'b0}}, best_idx_ff};

   lrts_store #(
      .DEPTH  (MAX_PROCS),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Slot compare: arrived, work left, strictly larger than the best so far
   assign cand_take = pend_ff && (rd_data.arrival <= time_ff) && (rd_data.remaining != '0)
                      && (!found_ff || (rd_data.remaining > best_ff.remaining));

   // Result arithmetic for the chosen slot
   assign done_time = (time_ff == lrts_pkg::TIME_MAX) ? time_ff : time_ff + TW'(1);
   assign resp_time = time_ff - best_ff.arrival;
   assign tat_time  = done_time - best_ff.arrival;
   assign wait_time = (tat_time >= best_ff.burst) ? tat_time - best_ff.burst : '0;
   assign fin       = (best_ff.remaining == TW'(1));

   // Memory write: a load request in idle, or write-back of the chosen slot
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_ff;
      rd_addr = issue_cnt_ff[IDX_W-1:0];
      if (state_ff == ST_IDLE) begin
         wr_en             = accept && (req_operation == lrts_pkg::OP_LOAD) && slot_ok;
         wr_addr           = slot_ext[IDX_W-1:0];
         wr_data.started   = 1'b0;
         wr_data.arrival   = req_arrival_time;
         wr_data.burst     = req_burst_length;
         wr_data.remaining = req_burst_length;
      end else if (state_ff == ST_RESULT) begin
         wr_en             = found_ff;
         wr_data.started   = 1'b1;
         wr_data.remaining = best_ff.remaining - TW'(1);
      end
   end

   // Sequencer: issue reads, compare one slot a cycle, then retire the request
   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      issue_cnt_in = issue_cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      if (cand_take) begin
         found_in    = 1'b1;
         best_idx_in = pend_idx_ff;
         best_in     = rd_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == lrts_pkg::OP_TICK)) begin
               state_in     = ST_SCAN;
               issue_cnt_in = '0;
               found_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (issue_cnt_ff == limit) begin
               state_in = ST_RESULT;
            end else begin
               pend_in      = 1'b1;
               pend_idx_in  = issue_cnt_ff[IDX_W-1:0];
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
         end
         ST_RESULT: begin
            time_in  = done_time;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         time_ff   <= '0;
         active_ff <= '0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         time_ff  <= time_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         if (csr_write_enable) begin
            active_ff <= csr_write_data;
         end
      end
   end

   // Scan datapath registers
   always_ff @(posedge clock) begin
      issue_cnt_ff <= issue_cnt_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
   end

   // Strobe for one cycle after the result cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_RESULT);
      end
   end

   // Register the result fields; unused fields read zero
   always_ff @(posedge clock) begin
      if (state_ff == ST_RESULT) begin
         rsp_slot_time_ff  <= time_ff;
         rsp_idle_ff       <= !found_ff;
         rsp_chosen_ff     <= found_ff ? chosen_ext[PW-1:0] : '0;
         rsp_first_ff      <= found_ff && !best_ff.started;
         rsp_response_ff   <= (found_ff && !best_ff.started) ? resp_time : '0;
         rsp_finished_ff   <= found_ff && fin;
         rsp_completion_ff <= (found_ff && fin) ? done_time : '0;
         rsp_waiting_ff    <= (found_ff && fin) ? wait_time : '0;
         rsp_turnaround_ff <= (found_ff && fin) ? tat_time : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot_time       = rsp_slot_time_ff;
   assign rsp_idle            = rsp_idle_ff;
   assign rsp_chosen_process  = rsp_chosen_ff;
   assign rsp_first_run       = rsp_first_ff;
   assign rsp_response_time   = rsp_response_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_completion_time = rsp_completion_ff;
   assign rsp_waiting_time    = rsp_waiting_ff;
   assign rsp_turnaround_time = rsp_turnaround_ff;

   // Checks
   `LRTS_ASSERT_NEXT(a_tick_busy, clock, reset, accept && (req_operation == lrts_pkg::OP_TICK), busy, "tick request did not raise busy")
   `LRTS_ASSERT_NEXT(a_result_strobe, clock, reset, state_ff == ST_RESULT, rsp_valid && !busy, "result cycle not followed by strobe")
   `LRTS_ASSERT_SAME(a_idle_clean, clock, reset, rsp_valid && rsp_idle, !rsp_first_run && !rsp_finished && (rsp_chosen_process == '0), "idle result carries a choice")
   `LRTS_ASSERT_SAME(a_wait_le_tat, clock, reset, rsp_valid && rsp_finished, rsp_waiting_time <= rsp_turnaround_time, "waiting time above turnaround")

endmodule
